### rtl/its_pkg.sv
// Shared types, widths and codes for the integer set table.
package its_pkg;

    localparam int DATA_W       = 32;
    localparam int POS_W        = 6;
    localparam int ENTRY_CNT_W  = 7;
    localparam int DEF_CAPACITY = 64;

    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_PRESENT = 2'd1;
    localparam logic [1:0] ST_ABSENT  = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    typedef struct packed {
        logic [1:0]               command;
        logic signed [DATA_W-1:0] value;
    } its_item_t;

    typedef struct packed {
        logic [1:0]             status;
        logic [POS_W-1:0]       position;
        logic [ENTRY_CNT_W-1:0] entry_count;
    } its_result_t;

endpackage

### rtl/its_cell.sv
// One table slot: holds an entry and passes the search transaction to its neighbor.
module its_cell #(
    parameter int CAPACITY = its_pkg::DEF_CAPACITY,
    parameter int INDEX    = 0,
    parameter int IDX_W    = $clog2(CAPACITY),
    parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      advance,
    input  logic [CNT_W-1:0]          count,
    input  logic                      wr_en,
    input  logic [IDX_W-1:0]          wr_idx,
    input  logic [its_pkg::DATA_W-1:0] wr_data,
    input  logic                      prev_valid,
    input  logic [its_pkg::DATA_W-1:0] prev_key,
    input  logic                      prev_found,
    input  logic [IDX_W-1:0]          prev_idx,
    input  logic [its_pkg::DATA_W-1:0] prev_last,
    output logic                      next_valid,
    output logic [its_pkg::DATA_W-1:0] next_key,
    output logic                      next_found,
    output logic [IDX_W-1:0]          next_idx,
    output logic [its_pkg::DATA_W-1:0] next_last
);
    import its_pkg::*;

    logic [DATA_W-1:0] entry_reg;
    logic              valid_reg;
    logic [DATA_W-1:0] key_reg;
    logic              found_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [DATA_W-1:0] last_reg;

    logic              occupied;
    logic              is_last;
    logic              hit;
    logic              found_next;
    logic [IDX_W-1:0]  idx_next;
    logic [DATA_W-1:0] last_next;

    // Compare against the held entry; keep the first match and grab the last entry
    always_comb
    begin
        occupied   = (CNT_W'(INDEX) < count);
        is_last    = (CNT_W'(INDEX + 1) == count);
        hit        = occupied && (entry_reg == prev_key);
        found_next = prev_found || hit;
        idx_next   = (!prev_found && hit) ? IDX_W'(INDEX) : prev_idx;
        last_next  = is_last ? entry_reg : prev_last;
    end

    // Store a write aimed at this slot
    always_ff @(posedge clk)
    begin
        if (wr_en && (wr_idx == IDX_W'(INDEX)))
        begin
            entry_reg <= wr_data;
        end
    end

    // Advance the transaction valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= prev_valid;
        end
    end

    // Advance the transaction payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            key_reg   <= prev_key;
            found_reg <= found_next;
            idx_reg   <= idx_next;
            last_reg  <= last_next;
        end
    end

    assign next_valid = valid_reg;
    assign next_key   = key_reg;
    assign next_found = found_reg;
    assign next_idx   = idx_reg;
    assign next_last  = last_reg;

endmodule

### rtl/integer_set_table.sv
// Integer set table: a chain of slot cells searched by a passing transaction.
// Each item travels through CAPACITY cells, one per cycle unless the chain stalls on a
// waiting result; the result register loads as the item leaves the last cell, together
// with the table write-back. No new item is taken until the last one leaves the chain.
// A new item is accepted while a finished result still waits in the output register.
// Reset (rst_n, asynchronous) empties the table at once: count goes to zero, no sweep.
module integer_set_table #(
    parameter int CAPACITY = its_pkg::DEF_CAPACITY
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  its_pkg::its_item_t   item,
    output logic                 result_valid,
    input  logic                 result_ready,
    output its_pkg::its_result_t result
);
    import its_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic              busy_reg;
    logic              busy_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [1:0]        cmd_reg;
    logic              result_valid_reg;
    logic              result_valid_next;
    its_result_t       result_reg;
    its_result_t       result_next;

    logic              accept;
    logic              advance;
    logic              finish;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_idx;
    logic [DATA_W-1:0] wr_data;

    logic              chain_valid [CAPACITY+1];
    logic [DATA_W-1:0] chain_key   [CAPACITY+1];
    logic              chain_found [CAPACITY+1];
    logic [IDX_W-1:0]  chain_idx   [CAPACITY+1];
    logic [DATA_W-1:0] chain_last  [CAPACITY+1];

    // Handshake and chain control
    assign item_ready = !busy_reg;
    assign accept     = item_valid && item_ready;
    assign advance    = !(chain_valid[CAPACITY] && result_valid_reg && !result_ready);
    assign finish     = chain_valid[CAPACITY] && advance;

    // Inject a new search transaction at the head of the chain
    assign chain_valid[0] = accept;
    assign chain_key[0]   = item.value;
    assign chain_found[0] = 1'b0;
    assign chain_idx[0]   = '0;
    assign chain_last[0]  = '0;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            its_cell #(
                .CAPACITY (CAPACITY),
                .INDEX    (gi),
                .IDX_W    (IDX_W),
                .CNT_W    (CNT_W)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .advance    (advance),
                .count      (count_reg),
                .wr_en      (wr_en),
                .wr_idx     (wr_idx),
                .wr_data    (wr_data),
                .prev_valid (chain_valid[gi]),
                .prev_key   (chain_key[gi]),
                .prev_found (chain_found[gi]),
                .prev_idx   (chain_idx[gi]),
                .prev_last  (chain_last[gi]),
                .next_valid (chain_valid[gi+1]),
                .next_key   (chain_key[gi+1]),
                .next_found (chain_found[gi+1]),
                .next_idx   (chain_idx[gi+1]),
                .next_last  (chain_last[gi+1])
            );
        end
    endgenerate

    // Decide the command once the transaction leaves the last cell
    always_comb
    begin
        logic [1:0]       status;
        logic [IDX_W-1:0] slot;
        status     = ST_ABSENT;
        slot       = chain_idx[CAPACITY];
        count_next = count_reg;
        wr_en      = 1'b0;
        wr_idx     = chain_idx[CAPACITY];
        wr_data    = chain_key[CAPACITY];
        case (cmd_reg)
            CMD_ADD:
            begin
                if (chain_found[CAPACITY])
                begin
                    status = ST_PRESENT;
                end
                else if (count_reg == CNT_W'(CAPACITY))
                begin
                    status = ST_FULL;
                    slot   = '0;
                end
                else
                begin
                    status     = ST_DONE;
                    slot       = IDX_W'(count_reg);
                    wr_en      = finish;
                    wr_idx     = IDX_W'(count_reg);
                    count_next = count_reg + CNT_W'(1);
                end
            end
            CMD_REMOVE:
            begin
                if (chain_found[CAPACITY])
                begin
                    status     = ST_DONE;
                    wr_en      = finish;
                    wr_data    = chain_last[CAPACITY];
                    count_next = count_reg - CNT_W'(1);
                end
            end
            CMD_QUERY:
            begin
                status = chain_found[CAPACITY] ? ST_DONE : ST_ABSENT;
            end
            default:
            begin
                status = chain_found[CAPACITY] ? ST_DONE : ST_ABSENT;
            end
        endcase
        result_next.status      = status;
        result_next.position    = POS_W'(slot);
        result_next.entry_count = ENTRY_CNT_W'(count_next);
    end

    // Track the busy flag and the output register occupancy
    always_comb
    begin
        busy_next = busy_reg;
        if (accept)
        begin
            busy_next = 1'b1;
        end
        else if (finish)
        begin
            busy_next = 1'b0;
        end

        result_valid_next = result_valid_reg;
        if (finish)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg         <= 1'b0;
            count_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg         <= busy_next;
            result_valid_reg <= result_valid_next;
            if (finish)
            begin
                count_reg <= count_next;
            end
        end
    end

    // Capture the command and the result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= item.command;
        end
        if (finish)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule
